/* design/rfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the H.264 RTP FU-A packetizer: payload
// structs, queue job descriptor, config register codes and header constants.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam int LEN_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS  = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CFG_SYNC_SOURCE_ID = 2'd0;
    localparam logic [1:0] CFG_MAX_CHUNK      = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD_KIND   = 2'd2;

    localparam logic [15:0] MAX_CHUNK_RESET    = 16'd1350;
    localparam logic [6:0]  PAYLOAD_KIND_RESET = 7'd97;
    localparam logic [15:0] MIN_CHUNK          = 16'd2;

    localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
    localparam logic [7:0] NRI_MASK         = 8'he0;
    localparam logic [7:0] TYPE_MASK        = 8'h1f;
    localparam logic [7:0] FU_A_TYPE        = 8'd28;
    localparam logic [7:0] FU_START_BIT     = 8'h80;
    localparam logic [7:0] FU_END_BIT       = 8'h40;
    localparam logic [4:0] NAL_TYPE_SLICE   = 5'd1;
    localparam logic [4:0] NAL_TYPE_IDR     = 5'd5;

    localparam logic [3:0] HDR_BYTES = 4'd12;

    typedef struct packed {
        logic [7:0]  nal_byte;
        logic        first_byte;
        logic [15:0] nal_length;
        logic [31:0] rtp_timestamp;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       packet_end;
        logic       run_end;
    } t_out_item;

    typedef struct packed {
        logic        has_header;
        logic        marker;
        logic [15:0] seq;
        logic [31:0] timestamp;
        logic [1:0]  tail_count;
        logic [7:0]  tail0;
        logic [7:0]  tail1;
        logic [7:0]  tail2;
        logic        tail_pend;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* design/rfp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_front
// Accepts NAL bytes, tracks NAL and packet state and sequence numbers, and
// turns each byte into one job for the byte emitter (or none when dropped).
// ----------------------------------------------------------------------------
module rfp_front import rfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  t_in_item    i_item,
    input  logic [15:0] i_max_chunk,
    output logic        o_push,
    output t_job        o_job
);

    logic [15:0]         r_seq, n_seq;
    logic [LEN_BITS-1:0] r_nal_left, n_nal_left;
    logic [LEN_BITS-1:0] r_pkt_left, n_pkt_left;
    logic [7:0]          r_frag_hdr, n_frag_hdr;
    logic [31:0]         r_held_ts, n_held_ts;
    logic                r_fragmenting, n_fragmenting;
    logic                r_discarding, n_discarding;

    logic [LEN_BITS-1:0] limit;
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] chunk;
    logic [7:0]          b;
    logic                last;

    always_comb begin
        b     = i_item.nal_byte;
        limit = (i_max_chunk < MIN_CHUNK) ? LEN_BITS'(MIN_CHUNK) : LEN_BITS'(i_max_chunk);
        len   = LEN_BITS'(i_item.nal_length);
        if (len == '0) begin
            len = LEN_BITS'(1);
        end
        last  = (r_nal_left <= limit);
        chunk = last ? r_nal_left : limit;

        n_seq         = r_seq;
        n_nal_left    = r_nal_left;
        n_pkt_left    = r_pkt_left;
        n_frag_hdr    = r_frag_hdr;
        n_held_ts     = r_held_ts;
        n_fragmenting = r_fragmenting;
        n_discarding  = r_discarding;

        o_push           = 1'b0;
        o_job.has_header = 1'b0;
        o_job.marker     = 1'b0;
        o_job.seq        = r_seq;
        o_job.timestamp  = r_held_ts;
        o_job.tail_count = 2'd1;
        o_job.tail0      = b;
        o_job.tail1      = b;
        o_job.tail2      = b;
        o_job.tail_pend  = 1'b0;

        if (i_accept) begin
            if (i_item.first_byte) begin
                n_held_ts       = i_item.rtp_timestamp;
                n_frag_hdr      = b;
                o_job.timestamp = i_item.rtp_timestamp;
                if ((b[4:0] != NAL_TYPE_SLICE) && (b[4:0] != NAL_TYPE_IDR)) begin
                    n_discarding  = 1'b1;
                    n_fragmenting = 1'b0;
                    n_nal_left    = '0;
                    n_pkt_left    = '0;
                end else begin
                    o_push           = 1'b1;
                    o_job.has_header = 1'b1;
                    n_discarding     = 1'b0;
                    n_nal_left       = len - LEN_BITS'(1);
                    n_seq            = r_seq + 16'd1;
                    if (len <= limit) begin
                        n_fragmenting    = 1'b0;
                        o_job.marker     = 1'b1;
                        o_job.tail_count = 2'd1;
                        n_pkt_left       = len - LEN_BITS'(1);
                    end else begin
                        n_fragmenting    = 1'b1;
                        o_job.tail_count = 2'd2;
                        o_job.tail0      = (b & NRI_MASK) | FU_A_TYPE;
                        o_job.tail1      = (b & TYPE_MASK) | FU_START_BIT;
                        n_pkt_left       = limit - LEN_BITS'(1);
                    end
                    o_job.tail_pend = (n_pkt_left == '0);
                end
            end else if (!r_discarding && (r_nal_left != '0)) begin
                o_push = 1'b1;
                if (r_pkt_left == '0) begin
                    o_job.has_header = 1'b1;
                    o_job.marker     = last;
                    n_seq            = r_seq + 16'd1;
                    if (r_fragmenting) begin
                        o_job.tail_count = 2'd3;
                        o_job.tail0      = (r_frag_hdr & NRI_MASK) | FU_A_TYPE;
                        o_job.tail1      = (r_frag_hdr & TYPE_MASK) |
                                           (last ? FU_END_BIT : 8'h00);
                    end
                    n_pkt_left = chunk - LEN_BITS'(1);
                end else begin
                    n_pkt_left = r_pkt_left - LEN_BITS'(1);
                end
                n_nal_left      = r_nal_left - LEN_BITS'(1);
                o_job.tail_pend = (n_pkt_left == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq         <= '0;
            r_nal_left    <= '0;
            r_pkt_left    <= '0;
            r_frag_hdr    <= '0;
            r_held_ts     <= '0;
            r_fragmenting <= 1'b0;
            r_discarding  <= 1'b0;
        end else begin
            r_seq         <= n_seq;
            r_nal_left    <= n_nal_left;
            r_pkt_left    <= n_pkt_left;
            r_frag_hdr    <= n_frag_hdr;
            r_held_ts     <= n_held_ts;
            r_fragmenting <= n_fragmenting;
            r_discarding  <= n_discarding;
        end
    end

endmodule

/* design/rfp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_queue
// Small job queue between the front and the byte emitter.
// ----------------------------------------------------------------------------
module rfp_queue import rfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QPTR_BITS:0]   r_count, n_count;
    logic                 do_push;
    logic                 do_pop;

    always_comb begin
        o_stat.full  = (r_count == (QPTR_BITS+1)'(QUEUE_DEPTH));
        o_stat.empty = (r_count == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        n_wr         = do_push ? r_wr + QPTR_BITS'(1) : r_wr;
        n_rd         = do_pop ? r_rd + QPTR_BITS'(1) : r_rd;
        n_count      = r_count + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
        o_job        = r_mem[r_rd];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

/* design/rfp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_back
// Byte emitter: expands each job into those of RTP header, FU bytes and payload
// byte it carries, one byte per unstalled cycle into a registered output stage.
// ----------------------------------------------------------------------------
module rfp_back import rfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    input  logic [31:0] i_sync_source_id,
    input  logic [6:0]  i_payload_kind,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_job       r_job, n_job;
    logic       r_busy, n_busy;
    logic [3:0] r_pos, n_pos;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic       out_free;
    logic       is_last;
    logic [3:0] last_pos;
    logic [7:0] cur_byte;

    always_comb begin
        out_free = !r_out_valid || !i_out_stall;
        last_pos = HDR_BYTES + 4'(r_job.tail_count) - 4'd1;
        is_last  = (r_pos == last_pos);

        case (r_pos)
            4'd0:    cur_byte = RTP_VERSION_BYTE;
            4'd1:    cur_byte = {r_job.marker, i_payload_kind};
            4'd2:    cur_byte = r_job.seq[15:8];
            4'd3:    cur_byte = r_job.seq[7:0];
            4'd4:    cur_byte = r_job.timestamp[31:24];
            4'd5:    cur_byte = r_job.timestamp[23:16];
            4'd6:    cur_byte = r_job.timestamp[15:8];
            4'd7:    cur_byte = r_job.timestamp[7:0];
            4'd8:    cur_byte = i_sync_source_id[31:24];
            4'd9:    cur_byte = i_sync_source_id[23:16];
            4'd10:   cur_byte = i_sync_source_id[15:8];
            4'd11:   cur_byte = i_sync_source_id[7:0];
            4'd12:   cur_byte = r_job.tail0;
            4'd13:   cur_byte = r_job.tail1;
            default: cur_byte = r_job.tail2;
        endcase

        n_job       = r_job;
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (r_busy && out_free) begin
            n_out_valid         = 1'b1;
            n_out.out_byte      = cur_byte;
            n_out.packet_end    = is_last && r_job.tail_pend;
            n_out.run_end       = is_last;
            n_pos               = r_pos + 4'd1;
            if (is_last) begin
                n_busy = 1'b0;
            end
        end

        o_pop = !i_q_stat.empty && (!r_busy || (out_free && is_last));
        if (o_pop) begin
            n_job  = i_job;
            n_busy = 1'b1;
            n_pos  = i_job.has_header ? 4'd0 : HDR_BYTES;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_pos <= n_pos;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* design/h264_rtp_fua_packetizer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_top
// H.264 RTP packetizer (single NAL unit or FU-A), one NAL byte in per request,
// RTP packet bytes out one per cycle while the output is not stalled.
// path: accepted byte -> job queue -> emitter job register -> registered output
// throughput: one input byte per cycle while payload flows and the output is
//   not stalled; a packet start adds 12 header bytes and up to two FU bytes
// the 4-entry job queue absorbs header bursts before input stalls
// reset: synchronous active low, clears control state, config back to defaults
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_top import rfp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0] r_sync_source_id;
    logic [15:0] r_max_chunk;
    logic [6:0]  r_payload_kind;

    t_q_stat q_stat;
    t_job    push_job;
    t_job    head_job;
    logic    push;
    logic    pop;
    logic    accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_source_id <= '0;
            r_max_chunk      <= MAX_CHUNK_RESET;
            r_payload_kind   <= PAYLOAD_KIND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SYNC_SOURCE_ID: r_sync_source_id <= i_cfg_data;
                CFG_MAX_CHUNK:      r_max_chunk      <= i_cfg_data[15:0];
                CFG_PAYLOAD_KIND:   r_payload_kind   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_in_stall = q_stat.full;
    assign accept     = i_in_valid && !q_stat.full;

    rfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .i_max_chunk (r_max_chunk),
        .o_push      (push),
        .o_job       (push_job)
    );

    rfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    rfp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (head_job),
        .i_q_stat         (q_stat),
        .o_pop            (pop),
        .i_sync_source_id (r_sync_source_id),
        .i_payload_kind   (r_payload_kind),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_data       (o_out_data)
    );

endmodule
